FILE: design/importance_split_roulette_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the importance split / roulette core
// Clocked property wrappers, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef IMPORTANCE_SPLIT_ROULETTE_CORE_ASSERT_SVH
`define IMPORTANCE_SPLIT_ROULETTE_CORE_ASSERT_SVH

// Property is ignored while reset is asserted.
`define ISR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property is checked on every edge, reset included.
`define ISR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/isr_pkg.sv
// ----------------------------------------------------------------------------
// isr_pkg
// Shared widths, constants, state and command types for the split/roulette core.
// ----------------------------------------------------------------------------
`default_nettype none

package isr_pkg;

    localparam int WORD_W       = 32;
    localparam int PROD_W       = 2 * WORD_W;
    localparam int COUNT_W      = 16;
    localparam int RAND_FIELD_W = 16;

    localparam int IN_TDATA_W   = 3 * WORD_W + RAND_FIELD_W;
    localparam int OUT_TDATA_W  = COUNT_W + WORD_W;
    localparam int OUT_TUSER_W  = 3;

    // m_tuser bit positions
    localparam int TUSER_ERROR  = 0;
    localparam int TUSER_HIGH   = 1;
    localparam int TUSER_LOW    = 2;

    localparam int DIV_STEPS    = WORD_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0]  LOW_BOUND_RESET = WORD_W'(66);
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [WORD_W-1:0]  WORD_MAX        = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_W,
        ST_MUL_B,
        ST_MUL_R,
        ST_DIV,
        ST_DONE
    } isr_state_t;

    typedef enum logic [1:0] {
        MSEL_WEIGHT,
        MSEL_BOUND,
        MSEL_RAND
    } isr_mul_sel_t;

    typedef struct packed {
        logic         latch_in;
        logic         mul_en;
        isr_mul_sel_t mul_sel;
        logic         div_load;
        logic         div_step;
        logic         out_load;
    } isr_cmd_t;

endpackage

`default_nettype wire

FILE: design/isr_div.sv
// ----------------------------------------------------------------------------
// isr_div
// Restoring divider, one quotient bit per step. The high half of the
// dividend must be below the divisor so the quotient fits one word.
// ----------------------------------------------------------------------------
`default_nettype none

module isr_div
    import isr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              load,
    input  wire logic              step,
    input  wire logic [WORD_W-1:0] num_hi,
    input  wire logic [WORD_W-1:0] num_lo,
    input  wire logic [WORD_W-1:0] divisor,
    output logic      [WORD_W-1:0] quot,
    output logic      [WORD_W-1:0] rem
);

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] shf_reg, shf_next;
    logic [WORD_W-1:0] div_reg;
    logic [WORD_W:0]   trial;
    logic              fits;

    always_comb begin
        trial    = {rem_reg, shf_reg[WORD_W-1]};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? WORD_W'(trial - {1'b0, div_reg}) : trial[WORD_W-1:0];
        shf_next = {shf_reg[WORD_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= num_hi;
            shf_reg <= num_lo;
            div_reg <= divisor;
        end else if (step) begin
            rem_reg <= rem_next;
            shf_reg <= shf_next;
        end
    end

    assign quot = shf_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: design/isr_ctrl.sv
// ----------------------------------------------------------------------------
// isr_ctrl
// Sequencer: accept, multiply states (weight, bound, random), divide steps, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module isr_ctrl
    import isr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output isr_cmd_t  cmd
);

    isr_state_t           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 ovalid_reg, ovalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        cmd          = '0;
        cmd.mul_sel  = MSEL_WEIGHT;
        s_tready     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_MUL_W;
                end
            end
            ST_MUL_W: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_WEIGHT;
                state_next  = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_BOUND;
                state_next  = ST_MUL_R;
            end
            ST_MUL_R: begin
                // weight product is ready here, so the dividers load too
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MSEL_RAND;
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!ovalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = ovalid_reg;

endmodule

`default_nettype wire

FILE: design/isr_dp.sv
// ----------------------------------------------------------------------------
// isr_dp
// Datapath: operand registers, shared multiplier, two dividers, result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module isr_dp
    import isr_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int RAND_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire isr_cmd_t              cmd,
    input  wire logic [IN_TDATA_W-1:0] in_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [WORD_W-1:0]     cfg_wr_data,
    output logic      [COUNT_W-1:0]    split_count,
    output logic      [WORD_W-1:0]     weight_out,
    output logic                       error_flag,
    output logic                       warn_high,
    output logic                       warn_low
);

    localparam int RW   = (RAND_BITS < RAND_FIELD_W) ? RAND_BITS : RAND_FIELD_W;
    localparam int RP_W = WORD_W + RW;

    logic [WORD_W-1:0] bound_reg;
    logic              high_seen_reg;

    logic [WORD_W-1:0] pre_reg, post_reg, w_reg;
    logic [RW-1:0]     rnd_reg;

    logic [WORD_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0] wp_reg, bp_reg;
    logic [RP_W-1:0]   rp_reg;

    logic              wsat;
    logic              wsat_reg;
    logic [WORD_W-1:0] wq, cq, crem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_reg <= LOW_BOUND_RESET;
        end else if (cfg_wr_en) begin
            bound_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            pre_reg  <= in_data[WORD_W-1:0];
            post_reg <= in_data[2*WORD_W-1:WORD_W];
            w_reg    <= in_data[3*WORD_W-1:2*WORD_W];
            rnd_reg  <= in_data[3*WORD_W+RW-1:3*WORD_W];
        end
    end

    // one 32x32 multiplier shared by the weight, bound and random products
    always_comb begin
        unique case (cmd.mul_sel)
            MSEL_WEIGHT: begin
                mul_a = w_reg;
                mul_b = pre_reg;
            end
            MSEL_BOUND: begin
                mul_a = bound_reg;
                mul_b = post_reg;
            end
            MSEL_RAND: begin
                mul_a = WORD_W'(rnd_reg);
                mul_b = pre_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            case (cmd.mul_sel)
                MSEL_WEIGHT: wp_reg <= mul_p;
                MSEL_BOUND:  bp_reg <= mul_p;
                default:     rp_reg <= mul_p[RP_W-1:0];
            endcase
        end
    end

    // quotient of w*pre/post overflows one word when the high half reaches post
    assign wsat = wp_reg[PROD_W-1:WORD_W] >= post_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            wsat_reg <= wsat;
        end
    end

    isr_div u_wdiv (
        .aclk    (aclk),
        .load    (cmd.div_load),
        .step    (cmd.div_step),
        .num_hi  (wsat ? '0 : wp_reg[PROD_W-1:WORD_W]),
        .num_lo  (wp_reg[WORD_W-1:0]),
        .divisor (post_reg),
        .quot    (wq),
        .rem     ()
    );

    isr_div u_cdiv (
        .aclk    (aclk),
        .load    (cmd.div_load),
        .step    (cmd.div_step),
        .num_hi  ('0),
        .num_lo  (post_reg),
        .divisor (pre_reg),
        .quot    (cq),
        .rem     (crem)
    );

    logic               post_zero, pre_zero;
    logic               high_cmp, low_cmp;
    logic               whigh, wlow, err;
    logic [PROD_W-1:0]  pre_shift, rem_shift, diff_shift, rp_ext;
    logic               extra, kill;
    logic [WORD_W:0]    n_ext;
    logic [COUNT_W-1:0] n_sat, count_val;
    logic [WORD_W-1:0]  wsat_val, wout_val;

    always_comb begin
        post_zero  = post_reg == '0;
        pre_zero   = pre_reg == '0;
        high_cmp   = {2'b00, pre_reg} > {post_reg, 2'b00};
        pre_shift  = PROD_W'(pre_reg) << FRAC_BITS;
        low_cmp    = pre_shift < bp_reg;
        whigh      = !post_zero && high_cmp && !high_seen_reg;
        wlow       = !post_zero && !whigh && low_cmp;
        err        = !post_zero && (pre_zero || w_reg == '0);

        rp_ext     = PROD_W'(rp_reg);
        rem_shift  = PROD_W'(crem) << RAND_BITS;
        diff_shift = PROD_W'(WORD_W'(pre_reg - post_reg)) << RAND_BITS;
        extra      = (crem != '0) && (rp_ext < rem_shift);
        kill       = rp_ext < diff_shift;
        n_ext      = {1'b0, cq} + (WORD_W + 1)'(extra);
        n_sat      = (n_ext > (WORD_W + 1)'(COUNT_MAX)) ? COUNT_MAX : n_ext[COUNT_W-1:0];
        wsat_val   = wsat_reg ? WORD_MAX : wq;

        if (post_zero || pre_zero) begin
            count_val = '0;
            wout_val  = '0;
        end else if (pre_reg < post_reg) begin
            count_val = n_sat;
            wout_val  = wsat_val;
        end else if (pre_reg > post_reg) begin
            count_val = kill ? '0 : COUNT_W'(1);
            wout_val  = kill ? '0 : wsat_val;
        end else begin
            count_val = COUNT_W'(1);
            wout_val  = wsat_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_seen_reg <= 1'b0;
        end else if (cmd.out_load && whigh) begin
            high_seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            split_count <= count_val;
            weight_out  <= wout_val;
            error_flag  <= err;
            warn_high   <= whigh;
            warn_low    <= wlow;
        end
    end

endmodule

`default_nettype wire

FILE: design/importance_split_roulette_core.sv
// ----------------------------------------------------------------------------
// importance_split_roulette_core
// Importance splitting / Russian roulette decision for one track per beat.
// ----------------------------------------------------------------------------
//  channel   | dir | fields (low bit first)
//  ----------+-----+-----------------------------------------------------------
//  s_axis    | in  | tdata: importance_pre, importance_post, weight_in,
//            |     |        random_fraction
//  m_axis    | out | tdata: split_count, weight_out
//            |     | tuser: error_flag, warn_high, warn_low
//  cfg       | in  | cfg_wr_data: low_ratio_bound
//
//  One beat at a time: the accept, three products on the shared
//  32x32 multiplier, 32 steps of the two restoring dividers run side by side,
//  then the load of the result register.
//  A result waiting on m_tready does not block the next accept; the core
//  holds in its last cycle only if a previous result is still not taken.
//  aresetn (synchronous) clears the sequencer and high-warning flag; bound -> 66.
// ----------------------------------------------------------------------------
`default_nettype none

module importance_split_roulette_core
    import isr_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int RAND_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // importance_pre, importance_post, weight_in, random_fraction
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // split_count, weight_out
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // error_flag, warn_high, warn_low
    output logic      [OUT_TUSER_W-1:0] m_tuser,
    input  wire logic                   cfg_wr_en,
    input  wire logic [WORD_W-1:0]      cfg_wr_data
);

    isr_cmd_t           cmd;
    logic [COUNT_W-1:0] split_count;
    logic [WORD_W-1:0]  weight_out;

    isr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    isr_dp #(
        .FRAC_BITS (FRAC_BITS),
        .RAND_BITS (RAND_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_data     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .split_count (split_count),
        .weight_out  (weight_out),
        .error_flag  (m_tuser[TUSER_ERROR]),
        .warn_high   (m_tuser[TUSER_HIGH]),
        .warn_low    (m_tuser[TUSER_LOW])
    );

    assign m_tdata = {weight_out, split_count};

endmodule

`default_nettype wire

FILE: design/isr_chk.sv
// ----------------------------------------------------------------------------
// isr_chk
// Port-level checks for the split/roulette core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "importance_split_roulette_core_assert.svh"

module isr_chk
    import isr_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic [OUT_TUSER_W-1:0] m_tuser
);

    // a stalled result beat holds
    `ISR_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result beat changed while stalled")

    // one item at a time: no accept right after an accept
    `ISR_ASSERT(a_one_at_a_time, aclk, aresetn,
        s_tvalid && s_tready |=> !s_tready,
        "input accepted on consecutive cycles")

    // the two warnings never come together
    `ISR_ASSERT(a_warn_excl, aclk, aresetn,
        m_tvalid |-> !(m_tuser[TUSER_HIGH] && m_tuser[TUSER_LOW]),
        "warn_high and warn_low both set")

    // an error result always carries zero weight
    `ISR_ASSERT(a_err_zero_w, aclk, aresetn,
        m_tvalid && m_tuser[TUSER_ERROR] |-> m_tdata[OUT_TDATA_W-1:COUNT_W] == '0,
        "error beat with nonzero weight")

    `ISR_ASSERT_ALWAYS(a_reset_clears, aclk,
        !aresetn |=> !m_tvalid,
        "result valid after reset")

endmodule

bind importance_split_roulette_core isr_chk u_isr_chk (.*);

`default_nettype wire
